// File: design/kpd_pkg.sv
// Package: field widths and fixed constants of the key peak detector.
`default_nettype none
package kpd_pkg;

	localparam int CHANNEL_W = 4;
	localparam int THRESH_W  = 10;
	localparam int VEL_W     = 7;
	localparam int VEL_SHIFT = 3;

	localparam logic [THRESH_W-1:0] THRESH_RESET = 10'd250;
	localparam logic [VEL_W-1:0]    VEL_MAX      = 7'd127;

endpackage
`default_nettype wire

// File: design/kpd_ifs.sv
// Interfaces: sample stream, note event stream and threshold write channel.
`default_nettype none
interface kpd_in_if #(
	parameter int SAMPLE_BITS = 10
);
	logic                           valid;
	logic                           ready;
	logic [kpd_pkg::CHANNEL_W-1:0]  channel;
	logic [SAMPLE_BITS-1:0]         sample;
	logic                           release_pin;

	modport source (output valid, channel, sample, release_pin, input ready);
	modport sink   (input valid, channel, sample, release_pin, output ready);
endinterface

interface kpd_out_if;
	logic                           valid;
	logic                           ready;
	logic [kpd_pkg::CHANNEL_W-1:0]  note;
	logic                           is_note_on;
	logic [kpd_pkg::VEL_W-1:0]      velocity;

	modport source (output valid, note, is_note_on, velocity, input ready);
	modport sink   (input valid, note, is_note_on, velocity, output ready);
endinterface

interface kpd_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [kpd_pkg::THRESH_W-1:0]   data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// File: design/multichannel_key_peak_detector_top.sv
// Top level: per-channel slope-sign peak detector, note-on / note-off events.
// An accepted beat is registered in stage 1; its event then loads the output register.
// Throughput: one sample beat per cycle unless stage 1 holds an event and the output
// register is stuck; per-channel RAM read-modify-write uses forwarding from stage 1.
// Reset (arst_n low, async): threshold 250, all channels in press mode, zero
// history (per-entry valid flops, no clearing pass), pipeline and output empty.
`default_nettype none
module multichannel_key_peak_detector_top #(
	parameter int CHANNELS    = 16,
	parameter int SAMPLE_BITS = 10
) (
	input  wire  clk,
	input  wire  arst_n,
	kpd_in_if.sink     samples,
	kpd_out_if.source  events,
	kpd_cfg_if.sink    cfg
);

	// State RAM word: {awaiting_release, last_rising, last_sample}
	localparam int WORD_W = SAMPLE_BITS + 2;
	localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CMP_W  = (SAMPLE_BITS > kpd_pkg::THRESH_W) ? SAMPLE_BITS
		: kpd_pkg::THRESH_W;
	localparam logic [7:0] CH_LIMIT = 8'(CHANNELS);

	// ---------------- configuration ----------------
	logic [kpd_pkg::THRESH_W-1:0] thresh_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= kpd_pkg::THRESH_RESET;
		end else if (cfg.valid) begin
			thresh_q <= cfg.data;
		end
	end

	// ---------------- input decode ----------------
	logic [IDX_W+7:0] ch_ext;
	logic [IDX_W-1:0] idx_in;
	logic             inrng_in;
	logic             in_fire;
	logic             s1_adv;

	assign ch_ext   = (IDX_W+8)'(samples.channel);
	assign idx_in   = ch_ext[IDX_W-1:0];
	assign inrng_in = 8'(samples.channel) < CH_LIMIT;
	assign samples.ready = s1_adv;
	assign in_fire  = samples.valid && s1_adv;

	// ---------------- state RAM and stage 1 ----------------
	logic [WORD_W-1:0]              mem_q [CHANNELS];
	logic [CHANNELS-1:0]            valid_q;
	logic [WORD_W-1:0]              rd_word_s1;
	logic                           v_s1;
	logic [IDX_W-1:0]               idx_s1;
	logic                           inrng_s1;
	logic [kpd_pkg::CHANNEL_W-1:0]  ch_s1;
	logic [SAMPLE_BITS-1:0]         smp_s1;
	logic                           pin_s1;
	logic                           fwd_s1;
	logic [WORD_W-1:0]              fwd_word_s1;

	logic [WORD_W-1:0]      cur_word;
	logic                   cur_wait;
	logic                   cur_rise;
	logic [SAMPLE_BITS-1:0] cur_peak;
	logic                   rise_new;
	logic                   peak_over;
	logic                   emit_on;
	logic                   emit_off;
	logic                   emit;
	logic                   wr_en;
	logic [WORD_W-1:0]      new_word;
	logic [SAMPLE_BITS+7:0] vel_wide;
	logic [kpd_pkg::VEL_W-1:0] vel_sat;

	// latest copy of the entry: in-flight write first, then RAM, then reset value
	assign cur_word  = fwd_s1 ? fwd_word_s1 : (valid_q[idx_s1] ? rd_word_s1 : '0);
	assign cur_wait  = cur_word[WORD_W-1];
	assign cur_rise  = cur_word[SAMPLE_BITS];
	assign cur_peak  = cur_word[SAMPLE_BITS-1:0];

	assign rise_new  = smp_s1 > cur_peak;
	assign peak_over = CMP_W'(cur_peak) > CMP_W'(thresh_q);
	assign emit_on   = v_s1 && inrng_s1 && !cur_wait && cur_rise && !rise_new && peak_over;
	assign emit_off  = v_s1 && inrng_s1 && cur_wait && pin_s1;
	assign emit      = emit_on || emit_off;
	assign wr_en     = v_s1 && inrng_s1;

	always_comb begin
		if (!cur_wait) begin
			new_word = {emit_on, rise_new, smp_s1};
		end else begin
			// release mode keeps history; a high pin drops back to press mode
			new_word = {cur_wait && !pin_s1, cur_rise, cur_peak};
		end
	end

	assign vel_wide = (SAMPLE_BITS+8)'(cur_peak) >> kpd_pkg::VEL_SHIFT;
	assign vel_sat  = (vel_wide > (SAMPLE_BITS+8)'(kpd_pkg::VEL_MAX)) ? kpd_pkg::VEL_MAX
		: vel_wide[kpd_pkg::VEL_W-1:0];

	// stage 1 holds only when it carries an event and the output register is stuck
	logic ev_v_q;
	assign s1_adv = !emit || !ev_v_q || events.ready;

	// RAM: one read port (on accept), one write port (stage 1 write-back)
	always_ff @(posedge clk) begin
		if (in_fire) begin
			rd_word_s1 <= mem_q[idx_in];
		end
		if (wr_en && s1_adv) begin
			mem_q[idx_s1] <= new_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			v_s1    <= 1'b0;
			fwd_s1  <= 1'b0;
		end else begin
			if (wr_en && s1_adv) begin
				valid_q[idx_s1] <= 1'b1;
			end
			if (s1_adv) begin
				v_s1 <= in_fire;
			end
			if (in_fire) begin
				// same entry written at this edge: RAM read returns stale data
				fwd_s1 <= wr_en && (idx_s1 == idx_in);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			idx_s1      <= idx_in;
			inrng_s1    <= inrng_in;
			ch_s1       <= samples.channel;
			smp_s1      <= samples.sample;
			pin_s1      <= samples.release_pin;
			fwd_word_s1 <= new_word;
		end
	end

	// ---------------- output register ----------------
	logic [kpd_pkg::CHANNEL_W-1:0] ev_note_q;
	logic                          ev_on_q;
	logic [kpd_pkg::VEL_W-1:0]     ev_vel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_v_q <= 1'b0;
		end else if (emit && s1_adv) begin
			ev_v_q <= 1'b1;
		end else if (events.ready) begin
			ev_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && s1_adv) begin
			ev_note_q <= ch_s1;
			ev_on_q   <= emit_on;
			ev_vel_q  <= emit_on ? vel_sat : '0;
		end
	end

	assign events.valid      = ev_v_q;
	assign events.note       = ev_note_q;
	assign events.is_note_on = ev_on_q;
	assign events.velocity   = ev_vel_q;

`ifndef ASSERT_OFF
	// a stalled stage 1 keeps its item
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !s1_adv |=> v_s1 && $stable(idx_s1) && $stable(smp_s1))
		else $error("stage 1 item lost during stall");

	// note-off beats carry zero velocity
	a_off_vel: assert property (@(posedge clk) disable iff (!arst_n)
		events.valid && !events.is_note_on |-> events.velocity == '0)
		else $error("note-off with nonzero velocity");

	// input back-pressure only comes from a full, stalled output
	a_bp_src: assert property (@(posedge clk) disable iff (!arst_n)
		!samples.ready |-> events.valid && !events.ready)
		else $error("input stalled without output back-pressure");
`endif

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
// Testbench: key peak detector, directed and random sample streams checked against a predictor.
`default_nettype none
module tb;

	localparam int CHANNELS    = 16;
	localparam int SAMPLE_BITS = 10;
	localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
	localparam int THRESH_MAX  = (1 << kpd_pkg::THRESH_W) - 1;

	// Beat accepted at the input passes stage 1 and the output register before it shows up.
	localparam int PIPE_LAT    = 2;
	// Cycles with no beat on any channel before the run is called hung.
	localparam int STALL_LIMIT = 2000;
	// Random part: three idle profiles, four threshold settings each.
	localparam int PHASES      = 3;
	localparam int CHUNKS      = 4;
	localparam int CHUNK_ITEMS = 128;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [kpd_pkg::CHANNEL_W-1:0] note;
		logic                          is_note_on;
		logic [kpd_pkg::VEL_W-1:0]     velocity;
	} note_event_t;

	logic clk;
	logic arst_n;

	kpd_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) smp_ch ();
	kpd_out_if                             evt_ch ();
	kpd_cfg_if                             thr_ch ();

	multichannel_key_peak_detector_top #(
		.CHANNELS    (CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (smp_ch),
		.events  (evt_ch),
		.cfg     (thr_ch)
	);

	// Shadow of the block: threshold plus per-channel history and mode.
	logic [kpd_pkg::THRESH_W-1:0] press_thr;
	logic [SAMPLE_BITS-1:0] key_last_sample [CHANNELS];
	logic                   key_last_rising [CHANNELS];
	logic                   key_held        [CHANNELS];

	note_event_t pending_notes[$];
	int          mismatch_count;
	int          items_sent;
	int          send_idle_pct;
	int          recv_idle_pct;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver side: ready changes on the falling edge only.
	initial begin
		evt_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			evt_ch.ready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic void reset_shadow();
		press_thr = kpd_pkg::THRESH_RESET;
		for (int i = 0; i < CHANNELS; i++) begin
			key_last_sample[i] = '0;
			key_last_rising[i] = 1'b0;
			key_held[i]        = 1'b0;
		end
	endfunction

	// Advance the shadow by one sample beat; returns 1 when the beat fires an event.
	function automatic bit predict_note_event(
		input  logic [kpd_pkg::CHANNEL_W-1:0] ch,
		input  logic [SAMPLE_BITS-1:0] smp,
		input  logic                   pin,
		output note_event_t            ev
	);
		logic [SAMPLE_BITS-1:0] peak;
		logic [SAMPLE_BITS-1:0] scaled;
		logic                   was_rising;
		logic                   rising;
		ev = '0;
		if (int'(ch) >= CHANNELS)
			return 1'b0;
		if (!key_held[ch]) begin
			// Press mode: slope from previous sample, fire on rising -> not rising.
			peak       = key_last_sample[ch];
			was_rising = key_last_rising[ch];
			rising     = (smp > peak);
			key_last_sample[ch] = smp;
			key_last_rising[ch] = rising;
			if (was_rising && !rising && (peak > press_thr)) begin
				scaled = peak >> kpd_pkg::VEL_SHIFT;
				key_held[ch]  = 1'b1;
				ev.note       = ch;
				ev.is_note_on = 1'b1;
				ev.velocity   = (scaled > kpd_pkg::VEL_MAX) ? kpd_pkg::VEL_MAX
					: scaled[kpd_pkg::VEL_W-1:0];
				return 1'b1;
			end
			return 1'b0;
		end
		// Release mode: history frozen, only the pin matters.
		if (pin) begin
			key_held[ch]  = 1'b0;
			ev.note       = ch;
			ev.is_note_on = 1'b0;
			ev.velocity   = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic note_mismatch(input string why, input note_event_t exp_ev,
			input note_event_t got_ev);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("mismatch (%s): exp note %0d on %0b vel %0d, got note %0d on %0b vel %0d",
				why, exp_ev.note, exp_ev.is_note_on, exp_ev.velocity,
				got_ev.note, got_ev.is_note_on, got_ev.velocity);
	endtask

	// Everything is sampled at the rising edge. Output beats are checked before the
	// input beat of the same edge is predicted; an input beat can't reach the output
	// at the edge it is taken.
	always @(posedge clk) begin : scoreboard
		note_event_t exp_ev;
		note_event_t got_ev;
		if (arst_n) begin
			if (evt_ch.valid && evt_ch.ready) begin
				got_ev.note       = evt_ch.note;
				got_ev.is_note_on = evt_ch.is_note_on;
				got_ev.velocity   = evt_ch.velocity;
				if (pending_notes.size() == 0) begin
					note_mismatch("unexpected", '0, got_ev);
				end else begin
					exp_ev = pending_notes.pop_front();
					if (got_ev.note !== exp_ev.note || got_ev.is_note_on !== exp_ev.is_note_on ||
							got_ev.velocity !== exp_ev.velocity)
						note_mismatch("field", exp_ev, got_ev);
				end
			end
			if (smp_ch.valid && smp_ch.ready) begin
				if (predict_note_event(smp_ch.channel, smp_ch.sample, smp_ch.release_pin, exp_ev))
					pending_notes.push_back(exp_ev);
			end
			if (thr_ch.valid && thr_ch.ready)
				press_thr = thr_ch.data;
		end
	end

	// Hang detector: any beat on any channel restarts the count.
	initial begin : watchdog
		int stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((smp_ch.valid && smp_ch.ready) || (evt_ch.valid && evt_ch.ready) ||
					(thr_ch.valid && thr_ch.ready))
				stall = 0;
			else
				stall++;
		end
		$display("status: fail");
		$finish;
	end

	// One sample beat. Returns just after the falling edge that follows acceptance
	// with valid still high, so a back-to-back beat keeps valid up without a glitch.
	task automatic send_sample(input logic [kpd_pkg::CHANNEL_W-1:0] ch, input int smp,
			input logic pin);
		while ($urandom_range(99) < send_idle_pct) begin
			smp_ch.valid = 1'b0;
			@(negedge clk);
		end
		smp_ch.channel     = ch;
		smp_ch.sample      = smp[SAMPLE_BITS-1:0];
		smp_ch.release_pin = pin;
		smp_ch.valid       = 1'b1;
		@(posedge clk);
		while (!smp_ch.ready)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	// Stop sending, let every expected event out, then cover the pipeline depth
	// for beats that fire nothing. Leaves the block idle, at a falling edge.
	task automatic drain_events();
		smp_ch.valid = 1'b0;
		while (pending_notes.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 1) @(negedge clk);
	endtask

	task automatic write_threshold(input int thr);
		drain_events();
		thr_ch.data  = thr[kpd_pkg::THRESH_W-1:0];
		thr_ch.valid = 1'b1;
		@(posedge clk);
		while (!thr_ch.ready)
			@(posedge clk);
		@(negedge clk);
		thr_ch.valid = 1'b0;
	endtask

	// Reset threshold: peak one above fires, peak equal to it does not; release-mode
	// samples are dropped and the pin is ignored in press mode.
	task automatic test_default_threshold();
		send_sample(0, 251, 1'b0);
		send_sample(0, 100, 1'b1);   // note-on vel 31, pin ignored in press mode
		send_sample(0, SAMPLE_MAX, 1'b0); // held, pin low: nothing, not stored
		send_sample(0, 5, 1'b1);     // note-off
		send_sample(0, 6, 1'b0);     // compares against 100 kept from note-on
		send_sample(1, 250, 1'b0);
		send_sample(1, 250, 1'b0);   // flat top at threshold: no event
	endtask

	// Threshold at both extremes and one below the top; flat top counts as not rising.
	task automatic test_threshold_extremes();
		write_threshold(0);
		send_sample(15, 1, 1'b0);
		send_sample(15, 1, 1'b0);    // note-on vel 0
		send_sample(15, 0, 1'b1);    // note-off
		write_threshold(THRESH_MAX);
		send_sample(14, SAMPLE_MAX, 1'b0);
		send_sample(14, 0, 1'b0);    // peak can't exceed max threshold
		write_threshold(THRESH_MAX - 1);
		send_sample(14, SAMPLE_MAX, 1'b0);
		send_sample(14, THRESH_MAX - 1, 1'b0); // note-on vel 127
		send_sample(14, SAMPLE_MAX, 1'b0);
		send_sample(14, SAMPLE_MAX, 1'b1);     // note-off
	endtask

	// Two channels interleaved beat by beat, each keeping its own history.
	task automatic test_interleaved_channels();
		write_threshold(int'(kpd_pkg::THRESH_RESET));
		send_sample(2, 600, 1'b0);
		send_sample(3, 700, 1'b0);
		send_sample(2, 599, 1'b0);
		send_sample(3, 300, 1'b0);
		send_sample(2, 0, 1'b1);
		send_sample(3, 0, 1'b1);
	endtask

	task automatic send_noise();
		send_sample(kpd_pkg::CHANNEL_W'($urandom_range(CHANNELS - 1)),
			$urandom_range(SAMPLE_MAX), 1'($urandom_range(1)));
	endtask

	// One key stroke: release/floor, ramp to a peak, fall, a few held samples, release.
	// Noise on random channels is sprinkled in between.
	task automatic send_stroke(input logic [kpd_pkg::CHANNEL_W-1:0] ch);
		int peak;
		int steps;
		int step;
		int level;
		if (press_thr < THRESH_MAX && $urandom_range(99) < 80)
			peak = $urandom_range(SAMPLE_MAX, int'(press_thr) + 1);
		else
			peak = $urandom_range(SAMPLE_MAX);
		steps = $urandom_range(4, 1);
		step  = $urandom_range(80, 1);
		send_sample(ch, $urandom_range(20), 1'b1);
		for (int i = 0; i < steps; i++) begin
			if ($urandom_range(99) < 25)
				send_noise();
			level = peak - (steps - 1 - i) * step;
			if (level < 0)
				level = 0;
			send_sample(ch, level, 1'($urandom_range(1)));
		end
		send_sample(ch, $urandom_range(peak), 1'($urandom_range(1)));
		repeat ($urandom_range(2)) begin
			if ($urandom_range(99) < 25)
				send_noise();
			send_sample(ch, $urandom_range(SAMPLE_MAX), 1'b0);
		end
		if ($urandom_range(99) < 85)
			send_sample(ch, $urandom_range(SAMPLE_MAX), 1'b1);
	endtask

	// Random strokes under three idle profiles, a fresh threshold for every chunk.
	task automatic test_random_strokes();
		int chunk_end;
		int pick;
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 36;
					recv_idle_pct = 82;
				end
				1: begin
					send_idle_pct = 82;
					recv_idle_pct = 36;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int chunk = 0; chunk < CHUNKS; chunk++) begin
				pick = $urandom_range(9);
				if (pick == 0)
					write_threshold(0);
				else if (pick == 1)
					write_threshold(THRESH_MAX);
				else if (pick == 2)
					write_threshold(int'(kpd_pkg::THRESH_RESET));
				else
					write_threshold($urandom_range(THRESH_MAX));
				chunk_end = items_sent + CHUNK_ITEMS;
				while (items_sent < chunk_end) begin
					if ($urandom_range(99) < 15)
						send_noise();
					else
						send_stroke(kpd_pkg::CHANNEL_W'($urandom_range(CHANNELS - 1)));
				end
			end
		end
	endtask

	initial begin
		mismatch_count      = 0;
		items_sent          = 0;
		send_idle_pct       = 36;
		recv_idle_pct       = 82;
		smp_ch.valid        = 1'b0;
		smp_ch.channel      = '0;
		smp_ch.sample       = '0;
		smp_ch.release_pin  = 1'b0;
		thr_ch.valid        = 1'b0;
		thr_ch.data         = '0;
		reset_shadow();
		arst_n = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		test_default_threshold();
		test_threshold_extremes();
		test_interleaved_channels();
		test_random_strokes();

		drain_events();
		repeat (PIPE_LAT + 2) @(posedge clk);
		if (mismatch_count == 0 && pending_notes.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire

// File: files.f
design/kpd_pkg.sv
design/kpd_ifs.sv
design/multichannel_key_peak_detector_top.sv
tb/sv/tb.sv
